>>> src/affine2d_invert_defines.svh
// Assertion macros used by the affine inverse top level.
`ifndef AFFINE2D_INVERT_DEFINES_SVH
`define AFFINE2D_INVERT_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet in reset.
`define AFFINV_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("affine2d_invert: assertion failed");

// Next-cycle implication, sampled on clk, quiet in reset.
`define AFFINV_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("affine2d_invert: assertion failed");

`endif

>>> src/affinv_pkg.sv
// Types and constants of the affine inverse pipeline.
package affinv_pkg;

  localparam int COEFF_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int LANES       = 6;

  // det and numerator widths
  localparam int PW   = 2 * COEFF_WIDTH;
  localparam int DW   = 2 * COEFF_WIDTH + 1;
  localparam int DMW  = 2 * COEFF_WIDTH;
  localparam int SNW  = 2 * COEFF_WIDTH + FRAC_BITS + 1;
  localparam int NW   = 2 * COEFF_WIDTH + FRAC_BITS;
  localparam int CW   = (NW > DMW + COEFF_WIDTH) ? NW : DMW + COEFF_WIDTH;

  // lane order of the six quotients
  localparam int LANE_A  = 0;
  localparam int LANE_B  = 1;
  localparam int LANE_C  = 2;
  localparam int LANE_D  = 3;
  localparam int LANE_TX = 4;
  localparam int LANE_TY = 5;

  typedef struct packed {
    logic signed [COEFF_WIDTH-1:0] in_a;
    logic signed [COEFF_WIDTH-1:0] in_b;
    logic signed [COEFF_WIDTH-1:0] in_c;
    logic signed [COEFF_WIDTH-1:0] in_d;
    logic signed [COEFF_WIDTH-1:0] in_tx;
    logic signed [COEFF_WIDTH-1:0] in_ty;
  } affinv_in_t;

  typedef struct packed {
    logic signed [COEFF_WIDTH-1:0] out_a;
    logic signed [COEFF_WIDTH-1:0] out_b;
    logic signed [COEFF_WIDTH-1:0] out_c;
    logic signed [COEFF_WIDTH-1:0] out_d;
    logic signed [COEFF_WIDTH-1:0] out_tx;
    logic signed [COEFF_WIDTH-1:0] out_ty;
    logic                          invertible;
    logic                          saturated;
  } affinv_out_t;

  // products stage
  typedef struct packed {
    logic signed [COEFF_WIDTH-1:0] a;
    logic signed [COEFF_WIDTH-1:0] b;
    logic signed [COEFF_WIDTH-1:0] c;
    logic signed [COEFF_WIDTH-1:0] d;
    logic signed [PW-1:0]          ad;
    logic signed [PW-1:0]          bc;
    logic signed [PW-1:0]          cty;
    logic signed [PW-1:0]          dtx;
    logic signed [PW-1:0]          btx;
    logic signed [PW-1:0]          aty;
  } affinv_prod_t;

  // one quotient in flight; q bit COEFF_WIDTH flags overflow
  typedef struct packed {
    logic                   neg;
    logic [COEFF_WIDTH:0]   q;
    logic [NW-1:0]          rem;
  } affinv_lane_t;

  typedef struct packed {
    logic                          singular;
    logic [DMW-1:0]                den;
    affinv_lane_t [LANES-1:0]      lane;
  } affinv_work_t;

endpackage

>>> src/affinv_mul.sv
// First stage: the six coefficient products.
module affinv_mul (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  affinv_pkg::affinv_in_t up_item,
  input  logic                   dn_ready,
  output logic                   valid,
  output affinv_pkg::affinv_prod_t item
);

  affinv_pkg::affinv_prod_t next;

  // products, sign extended by context
  always_comb begin
    next.a   = up_item.in_a;
    next.b   = up_item.in_b;
    next.c   = up_item.in_c;
    next.d   = up_item.in_d;
    next.ad  = affinv_pkg::PW'(up_item.in_a) * affinv_pkg::PW'(up_item.in_d);
    next.bc  = affinv_pkg::PW'(up_item.in_b) * affinv_pkg::PW'(up_item.in_c);
    next.cty = affinv_pkg::PW'(up_item.in_c) * affinv_pkg::PW'(up_item.in_ty);
    next.dtx = affinv_pkg::PW'(up_item.in_d) * affinv_pkg::PW'(up_item.in_tx);
    next.btx = affinv_pkg::PW'(up_item.in_b) * affinv_pkg::PW'(up_item.in_tx);
    next.aty = affinv_pkg::PW'(up_item.in_a) * affinv_pkg::PW'(up_item.in_ty);
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= next;
    end
  end

endmodule

>>> src/affinv_num.sv
// Second stage: determinant, numerators, magnitudes and signs.
module affinv_num (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  affinv_pkg::affinv_prod_t up_item,
  input  logic                     dn_ready,
  output logic                     valid,
  output affinv_pkg::affinv_work_t item
);

  localparam int F   = affinv_pkg::FRAC_BITS;
  localparam int DW  = affinv_pkg::DW;
  localparam int SNW = affinv_pkg::SNW;

  logic signed [DW-1:0]  det;
  logic signed [DW-1:0]  det_abs;
  logic signed [SNW-1:0] n   [affinv_pkg::LANES];
  logic signed [SNW-1:0] mag [affinv_pkg::LANES];
  affinv_pkg::affinv_work_t next;

  always_comb begin
    det     = DW'(up_item.ad) - DW'(up_item.bc);
    det_abs = det[DW-1] ? -det : det;

    // numerators scaled to Q.3F before the divide
    n[affinv_pkg::LANE_A]  = SNW'(up_item.d) <<< (2 * F);
    n[affinv_pkg::LANE_B]  = (-SNW'(up_item.b)) <<< (2 * F);
    n[affinv_pkg::LANE_C]  = (-SNW'(up_item.c)) <<< (2 * F);
    n[affinv_pkg::LANE_D]  = SNW'(up_item.a) <<< (2 * F);
    n[affinv_pkg::LANE_TX] = (SNW'(up_item.cty) - SNW'(up_item.dtx)) <<< F;
    n[affinv_pkg::LANE_TY] = (SNW'(up_item.btx) - SNW'(up_item.aty)) <<< F;

    next.singular = (det == '0);
    next.den      = det_abs[affinv_pkg::DMW-1:0];
    for (int i = 0; i < affinv_pkg::LANES; i++) begin
      mag[i]             = n[i][SNW-1] ? -n[i] : n[i];
      next.lane[i].neg   = n[i][SNW-1] ^ det[DW-1];
      next.lane[i].q     = '0;
      next.lane[i].rem   = mag[i][affinv_pkg::NW-1:0];
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= next;
    end
  end

endmodule

>>> src/affinv_step.sv
// One restoring divide stage: decides quotient bit BIT for all six lanes.
module affinv_step #(
  parameter int BIT = 0
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  affinv_pkg::affinv_work_t up_item,
  input  logic                     dn_ready,
  output logic                     valid,
  output affinv_pkg::affinv_work_t item
);

  localparam int CW = affinv_pkg::CW;

  logic [CW-1:0] den_sh;
  logic [CW-1:0] rem_ext [affinv_pkg::LANES];
  affinv_pkg::affinv_work_t next;

  // compare and subtract the shifted divisor; top bit is the overflow test
  always_comb begin
    next   = up_item;
    den_sh = CW'(up_item.den) << BIT;
    for (int i = 0; i < affinv_pkg::LANES; i++) begin
      rem_ext[i] = CW'(up_item.lane[i].rem);
      if (rem_ext[i] >= den_sh) begin
        next.lane[i].rem    = affinv_pkg::NW'(rem_ext[i] - den_sh);
        next.lane[i].q[BIT] = 1'b1;
      end
    end
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= next;
    end
  end

endmodule

>>> src/affine2d_invert.sv
// Top level of the 2D affine matrix inverse pipeline.
// Takes one matrix per cycle while mat_stall is low and passes it through
// one stage of six 32x32 products, one stage that forms the determinant and the
// numerators, COEFF_WIDTH + 1 restoring divide stages that each decide one quotient bit
// for all six outputs (the first of them detects quotients too large for the field),
// and the output register that applies sign, saturation and the singular case.
// Every stage holds its own valid bit and stalls only when the stage after it is
// full and stalled, so empty slots close up and the input keeps flowing while a
// finished result waits at the output.
`include "affine2d_invert_defines.svh"

module affine2d_invert (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    mat_valid,
  output logic                    mat_stall,
  input  affinv_pkg::affinv_in_t  mat,
  output logic                    inv_valid,
  input  logic                    inv_stall,
  output affinv_pkg::affinv_out_t inv
);

  localparam int W = affinv_pkg::COEFF_WIDTH;
  localparam int NS = W + 2;

  logic                     mul_ready;
  logic                     mul_valid;
  affinv_pkg::affinv_prod_t mul_item;
  logic                     num_ready;
  logic                     vld  [NS];
  logic                     rdy  [NS];
  affinv_pkg::affinv_work_t work [NS];
  logic                     out_ready;

  logic [W-1:0]              val   [affinv_pkg::LANES];
  logic [affinv_pkg::LANES-1:0] sat_l;
  logic [W-1:0]              mag;
  logic                      ovf;
  affinv_pkg::affinv_out_t   res;

  localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

  assign mat_stall = !mul_ready;

  affinv_mul u_mul (
    .clk(clk), .rst(rst),
    .up_valid(mat_valid), .up_ready(mul_ready), .up_item(mat),
    .dn_ready(num_ready), .valid(mul_valid), .item(mul_item)
  );

  affinv_num u_num (
    .clk(clk), .rst(rst),
    .up_valid(mul_valid), .up_ready(num_ready), .up_item(mul_item),
    .dn_ready(rdy[0]), .valid(vld[0]), .item(work[0])
  );

  // divide stages, overflow bit first
  for (genvar s = 0; s <= W; s++) begin : g_step
    affinv_step #(.BIT(W - s)) u_step (
      .clk(clk), .rst(rst),
      .up_valid(vld[s]), .up_ready(rdy[s]), .up_item(work[s]),
      .dn_ready(rdy[s+1]), .valid(vld[s+1]), .item(work[s+1])
    );
  end

  assign out_ready = !inv_valid || !inv_stall;
  assign rdy[NS-1] = out_ready;

  // sign, clamp and singular handling
  always_comb begin
    mag = '0;
    ovf = 1'b0;
    for (int i = 0; i < affinv_pkg::LANES; i++) begin
      mag = work[NS-1].lane[i].q[W-1:0];
      ovf = work[NS-1].lane[i].q[W];
      if (work[NS-1].lane[i].neg) begin
        sat_l[i] = ovf || (mag[W-1] && (mag[W-2:0] != '0));
        val[i]   = sat_l[i] ? QMIN : W'(-mag);
      end else begin
        sat_l[i] = ovf || mag[W-1];
        val[i]   = sat_l[i] ? QMAX : mag;
      end
    end
    if (work[NS-1].singular) begin
      res = '0;
    end else begin
      res.out_a      = val[affinv_pkg::LANE_A];
      res.out_b      = val[affinv_pkg::LANE_B];
      res.out_c      = val[affinv_pkg::LANE_C];
      res.out_d      = val[affinv_pkg::LANE_D];
      res.out_tx     = val[affinv_pkg::LANE_TX];
      res.out_ty     = val[affinv_pkg::LANE_TY];
      res.invertible = 1'b1;
      res.saturated  = |sat_l;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_valid <= 1'b0;
    end else if (out_ready) begin
      inv_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && vld[NS-1]) begin
      inv <= res;
    end
  end

  `AFFINV_ASSERT_NOW(a_singular_zero, inv_valid && !inv.invertible, inv.out_a == '0 && inv.out_b == '0 && inv.out_c == '0 && inv.out_d == '0 && inv.out_tx == '0 && inv.out_ty == '0 && !inv.saturated)
  `AFFINV_ASSERT_NOW(a_sat_needs_inv, inv_valid && inv.saturated, inv.invertible)
  `AFFINV_ASSERT_NOW(a_stall_full, mat_stall, mul_valid)
  `AFFINV_ASSERT_NXT(a_accept_fills, mat_valid && !mat_stall, mul_valid)

endmodule

>>> test/tb.sv
// Self-checking testbench of the affine matrix inverse: directed table, then random matrices.
`timescale 1ns / 100ps

module tb;

  localparam int W = affinv_pkg::COEFF_WIDTH;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [W-1:0] ONE = 1 << affinv_pkg::FRAC_BITS;
  localparam int N_RANDOM = 1700;

  logic                    clk;
  logic                    rst;
  logic                    mat_valid;
  logic                    mat_stall;
  affinv_pkg::affinv_in_t  mat;
  logic                    inv_valid;
  logic                    inv_stall;
  affinv_pkg::affinv_out_t inv;

  affine2d_invert u_top (
    .clk(clk), .rst(rst),
    .mat_valid(mat_valid), .mat_stall(mat_stall), .mat(mat),
    .inv_valid(inv_valid), .inv_stall(inv_stall), .inv(inv)
  );

  // directed row: matrix, and an expected result when it is obvious
  typedef struct {
    affinv_pkg::affinv_in_t  m;
    bit                      has_exp;
    affinv_pkg::affinv_out_t e;
  } dir_row_t;

  affinv_pkg::affinv_out_t inverse_q[$];
  int          n_errors;
  int          n_checked;
  int          n_singular;
  int          n_sat;
  int          idle_cycles;
  bit          quiet_phase;
  bit          stim_done;

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // signed division truncated toward zero, clamped into the coefficient range
  function automatic logic signed [W-1:0] clamp_div(logic signed [191:0] num,
                                                    logic signed [191:0] den,
                                                    ref bit sat);
    logic signed [191:0] q;
    begin
      q = num / den;
      if (q > CMAX) begin
        sat = 1'b1;
        return CMAX;
      end
      if (q < CMIN) begin
        sat = 1'b1;
        return CMIN;
      end
      return q[W-1:0];
    end
  endfunction

  function automatic affinv_pkg::affinv_out_t invert_matrix(affinv_pkg::affinv_in_t m);
    logic signed [191:0] a, b, c, d, tx, ty, det;
    affinv_pkg::affinv_out_t r;
    bit sat;
    begin
      a = m.in_a; b = m.in_b; c = m.in_c; d = m.in_d; tx = m.in_tx; ty = m.in_ty;
      det = a * d - b * c;
      r = '0;
      sat = 1'b0;
      if (det != 0) begin
        r.out_a  = clamp_div(d <<< (2 * affinv_pkg::FRAC_BITS), det, sat);
        r.out_b  = clamp_div((-b) <<< (2 * affinv_pkg::FRAC_BITS), det, sat);
        r.out_c  = clamp_div((-c) <<< (2 * affinv_pkg::FRAC_BITS), det, sat);
        r.out_d  = clamp_div(a <<< (2 * affinv_pkg::FRAC_BITS), det, sat);
        r.out_tx = clamp_div((c * ty - d * tx) <<< affinv_pkg::FRAC_BITS, det, sat);
        r.out_ty = clamp_div((b * tx - a * ty) <<< affinv_pkg::FRAC_BITS, det, sat);
        r.invertible = 1'b1;
        r.saturated  = sat;
      end
      return r;
    end
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    $display("ERROR %0t: %s got %h want %h", $time, what, got, want);
    n_errors++;
  endtask

  // random coefficient: often near unity, some extremes, some raw noise
  function automatic logic signed [W-1:0] rand_coeff();
    int k;
    begin
      k = $urandom_range(0, 9);
      case (k)
        0: return CMAX;
        1: return CMIN;
        2: return $urandom_range(0, 3) - 1;
        3, 4: return $urandom;
        5: return $signed($urandom) >>> $urandom_range(0, 31);
        default: return ($signed($urandom) >>> 12) + ($urandom_range(0, 1) ? ONE : -ONE);
      endcase
    end
  endfunction

  function automatic affinv_pkg::affinv_in_t rand_matrix();
    affinv_pkg::affinv_in_t m;
    begin
      m.in_a = rand_coeff(); m.in_b = rand_coeff(); m.in_c = rand_coeff();
      m.in_d = rand_coeff(); m.in_tx = rand_coeff(); m.in_ty = rand_coeff();
      // force singular rows now and then: second row a multiple of the first
      if ($urandom_range(0, 15) == 0) begin
        m.in_c = m.in_a * 2;
        m.in_d = m.in_b * 2;
      end
      return m;
    end
  endfunction

  // send one matrix and record its expected inverse
  task automatic send_matrix(affinv_pkg::affinv_in_t m);
    begin
      while (!quiet_phase && $urandom_range(0, 99) < 22) begin
        mat_valid <= 1'b0;
        @(posedge clk);
      end
      mat_valid <= 1'b1;
      mat <= m;
      inverse_q.push_back(invert_matrix(m));
      @(posedge clk);
      while (mat_stall) @(posedge clk);
    end
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) inv_stall <= 1'b0;
    else inv_stall <= !quiet_phase && ($urandom_range(0, 99) < 22);
  end

  // result checker
  always @(posedge clk) begin
    affinv_pkg::affinv_out_t e;
    if (!rst && inv_valid && !inv_stall) begin
      if (inverse_q.size() == 0) begin
        report_mismatch("unexpected result", inv.out_a, '0);
      end else begin
        e = inverse_q.pop_front();
        n_checked++;
        if (!e.invertible) n_singular++;
        if (e.saturated) n_sat++;
        if (inv.out_a !== e.out_a) report_mismatch("out_a", inv.out_a, e.out_a);
        if (inv.out_b !== e.out_b) report_mismatch("out_b", inv.out_b, e.out_b);
        if (inv.out_c !== e.out_c) report_mismatch("out_c", inv.out_c, e.out_c);
        if (inv.out_d !== e.out_d) report_mismatch("out_d", inv.out_d, e.out_d);
        if (inv.out_tx !== e.out_tx) report_mismatch("out_tx", inv.out_tx, e.out_tx);
        if (inv.out_ty !== e.out_ty) report_mismatch("out_ty", inv.out_ty, e.out_ty);
        if (inv.invertible !== e.invertible)
          report_mismatch("invertible", inv.invertible, e.invertible);
        if (inv.saturated !== e.saturated)
          report_mismatch("saturated", inv.saturated, e.saturated);
      end
    end
  end

  // watchdog on cycles with no accepted item on either side
  always @(posedge clk) begin
    if (rst || (mat_valid && !mat_stall) || (inv_valid && !inv_stall)) begin
      idle_cycles <= 0;
    end else if (!stim_done || inverse_q.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("watchdog expired, %0d results outstanding", inverse_q.size());
        $display("affine2d_invert: mismatch");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    affinv_pkg::affinv_out_t z;
    int i;
    rst = 1'b1;
    mat_valid = 1'b0;
    mat = '0;
    n_errors = 0;
    n_checked = 0;
    n_singular = 0;
    n_sat = 0;
    quiet_phase = 1'b0;
    stim_done = 1'b0;
    z = '0;

    // all-zero matrix: singular, everything zero
    row.m = '0; row.has_exp = 1'b1; row.e = z; rows.push_back(row);
    // identity
    row.m = '{ONE, 0, 0, ONE, 0, 0}; row.e = '{ONE, 0, 0, ONE, 0, 0, 1'b1, 1'b0};
    rows.push_back(row);
    // identity with translation: inverse negates it
    row.m = '{ONE, 0, 0, ONE, 3 * ONE, -5 * ONE};
    row.e = '{ONE, 0, 0, ONE, -3 * ONE, 5 * ONE, 1'b1, 1'b0};
    rows.push_back(row);
    // extremes of the translation at identity
    row.m = '{ONE, 0, 0, ONE, CMAX, CMIN};
    row.e = '{ONE, 0, 0, ONE, CMIN + 1, CMAX, 1'b1, 1'b1};
    rows.push_back(row);
    // rank one: singular with nonzero translation
    row.m = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMIN}; row.e = z; rows.push_back(row);
    row.m = '{CMIN, CMIN, CMIN, CMIN, CMIN, CMAX}; row.e = z; rows.push_back(row);
    // remaining rows checked against the predictor only
    row.has_exp = 1'b0;
    row.m = '{1, 0, 0, 1, 0, 0}; rows.push_back(row);                 // tiny: saturates
    row.m = '{-1, 0, 0, 1, 1, -1}; rows.push_back(row);
    row.m = '{CMAX, 0, 0, CMAX, CMAX, CMAX}; rows.push_back(row);
    row.m = '{CMIN, 0, 0, CMIN, CMIN, CMIN}; rows.push_back(row);
    row.m = '{CMIN, CMAX, CMAX, CMIN, 1, -1}; rows.push_back(row);
    row.m = '{0, ONE, -ONE, 0, ONE, ONE}; rows.push_back(row);        // rotation
    row.m = '{2 * ONE, ONE, ONE, ONE, -7, 9}; rows.push_back(row);
    row.m = '{3 * ONE, 0, 0, 3 * ONE, ONE, ONE}; rows.push_back(row); // inexact thirds
    row.m = '{-3 * ONE, 0, 0, 3 * ONE, -ONE, ONE}; rows.push_back(row);
    row.m = '{ONE, 1, 1, ONE, CMAX, CMAX}; rows.push_back(row);
    row.m = '{-1, -1, -1, -1, -1, -1}; rows.push_back(row);
    row.m = '{CMAX, CMIN, 1, -1, 0, 0}; rows.push_back(row);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (rows[k]) begin
      if (rows[k].has_exp && invert_matrix(rows[k].m) !== rows[k].e)
        report_mismatch("directed row table", k, 0);
      send_matrix(rows[k].m);
    end

    // random matrices, with a stretch of full throughput in the middle
    for (i = 0; i < N_RANDOM; i++) begin
      quiet_phase = (i >= 700 && i < 1000);
      send_matrix(rand_matrix());
    end
    quiet_phase = 1'b0;
    mat_valid <= 1'b0;
    stim_done = 1'b1;

    while (inverse_q.size() != 0) @(posedge clk);
    repeat (affinv_pkg::COEFF_WIDTH + 10) @(posedge clk);

    $display("checked %0d inverses, %0d singular, %0d saturated",
             n_checked, n_singular, n_sat);
    if (n_errors == 0) begin
      $display("affine2d_invert: match");
    end else begin
      $display("%0d field mismatches", n_errors);
      $display("affine2d_invert: mismatch");
    end
    $finish;
  end

endmodule
